FILE: rtl/eefa_pkg.sv
// ----------------------------------------------------------------------------
// eefa_pkg
// Field widths and datapath sizes shared by the wide-exponent accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package eefa_pkg;

    localparam int FRAC_W    = 52;            // stored fraction bits
    localparam int SIG_W     = FRAC_W + 1;    // significand with hidden one
    localparam int EXT_W     = SIG_W + 3;     // significand with guard, round, sticky
    localparam int OP_EXP_W  = 32;            // exponent width on the ports
    localparam int FAR_SHIFT = 58;            // alignment gap that leaves only sticky
    localparam int TDATA_W   = 88;            // packed payload rounded to whole bytes

endpackage : eefa_pkg

`default_nettype wire

FILE: rtl/extended_exponent_float_accumulator.sv
// ----------------------------------------------------------------------------
// extended_exponent_float_accumulator
// Running floating-point sum with a 53-bit significand and wide exponent.
// ----------------------------------------------------------------------------
// Path: an input transfer is captured in the input register; the accumulator
// and the result register are then updated together, which waits while a
// pending result is not taken (one combinational pass between the two).
// Throughput: 1 item per cycle while m_axis_tready is high; the sum feeds back register to register.
// Reset: synchronous active low; the sum reads as zero, no result pending.
`default_nettype none

module extended_exponent_float_accumulator
    import eefa_pkg::*;
#(
    parameter int EXP_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [0] op_sign, [52:1] op_fraction, [84:53] op_exponent, [85] op_zero
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic               s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [0] sum_sign, [52:1] sum_fraction, [84:53] sum_exponent, [85] sum_zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    // [0] exp_saturated
    output logic                    m_axis_tuser
);

    localparam int XW = 66;
    localparam logic signed [XW-1:0] EMAX = (66'sd1 <<< (EXP_WIDTH - 1)) - 66'sd1;
    localparam logic signed [XW-1:0] EMIN = -EMAX - 66'sd1;

    // input register
    logic                       r_in_v;
    logic                       r_add;
    logic                       r_os;
    logic [FRAC_W-1:0]          r_of;
    logic [OP_EXP_W-1:0]        r_oe;
    logic                       r_oz;

    // accumulator
    logic                       r_acc_sign;
    logic [FRAC_W-1:0]          r_acc_frac;
    logic [EXP_WIDTH-1:0]       r_acc_exp;
    logic                       r_acc_zero;

    // result register
    logic                       r_out_v;
    logic                       r_out_sat;

    logic                       adv;
    logic                       fire;

    assign adv           = !r_out_v || m_axis_tready;
    assign fire          = r_in_v && adv;
    assign s_axis_tready = !r_in_v || adv;

    // capture the input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_v <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_add <= s_axis_tuser;
            r_os  <= s_axis_tdata[0];
            r_of  <= s_axis_tdata[FRAC_W:1];
            r_oe  <= s_axis_tdata[FRAC_W+OP_EXP_W:FRAC_W+1];
            r_oz  <= s_axis_tdata[FRAC_W+OP_EXP_W+1];
        end
    end

    // clamp the operand exponent to the accumulator range
    logic signed [XW-1:0]  oe_x;
    logic                  oe_sat;
    logic [EXP_WIDTH-1:0]  oe_c;

    always_comb begin
        oe_x   = {{(XW-OP_EXP_W){r_oe[OP_EXP_W-1]}}, r_oe};
        oe_sat = 1'b0;
        oe_c   = oe_x[EXP_WIDTH-1:0];
        if (oe_x > EMAX) begin
            oe_sat = 1'b1;
            oe_c   = EMAX[EXP_WIDTH-1:0];
        end else if (oe_x < EMIN) begin
            oe_sat = 1'b1;
            oe_c   = EMIN[EXP_WIDTH-1:0];
        end
    end

    // align, add or subtract, normalize and round
    logic signed [XW-1:0]  ea_x, eb_x, big_e, small_e, dgap, e_res;
    logic [SIG_W-1:0]      ma, mb, big_m, small_m;
    logic                  b_big, big_s, far, sticky, is_sub, cancel, rnd_sat;
    logic [5:0]            sh;
    logic [EXT_W-1:0]      v_small, v_big, shifted, small_al, dif, s_n;
    logic [EXT_W:0]        sum57;
    logic [5:0]            lz;
    logic                  found;
    logic signed [7:0]     adj;
    logic [SIG_W:0]        m_r;
    logic [FRAC_W-1:0]     frac_res;
    logic [EXP_WIDTH-1:0]  exp_res;

    always_comb begin
        ea_x    = {{(XW-EXP_WIDTH){r_acc_exp[EXP_WIDTH-1]}}, r_acc_exp};
        eb_x    = {{(XW-EXP_WIDTH){oe_c[EXP_WIDTH-1]}}, oe_c};
        ma      = {1'b1, r_acc_frac};
        mb      = {1'b1, r_of};
        b_big   = (eb_x > ea_x) || ((eb_x == ea_x) && (mb > ma));
        big_s   = b_big ? r_os : r_acc_sign;
        big_m   = b_big ? mb : ma;
        small_m = b_big ? ma : mb;
        big_e   = b_big ? eb_x : ea_x;
        small_e = b_big ? ea_x : eb_x;
        dgap    = big_e - small_e;
        far     = dgap >= 66'sd58;
        sh      = dgap[5:0];
        v_small = {small_m, 3'b000};
        v_big   = {big_m, 3'b000};
        shifted = v_small >> sh;
        sticky  = (shifted << sh) != v_small;
        small_al = far ? EXT_W'(1) : (shifted | {{(EXT_W-1){1'b0}}, sticky});

        is_sub = r_os != r_acc_sign;
        sum57  = {1'b0, v_big} + {1'b0, small_al};
        dif    = v_big - small_al;
        cancel = is_sub && (dif == '0);

        // leading zero count of the difference from bit 55 down
        lz    = '0;
        found = 1'b0;
        for (int i = EXT_W - 1; i >= 0; i--) begin
            if (!found && dif[i]) begin
                found = 1'b1;
                lz    = 6'(EXT_W - 1 - i);
            end
        end

        if (is_sub) begin
            s_n = dif << lz;
            adj = -$signed({2'b00, lz});
        end else if (sum57[EXT_W]) begin
            s_n = sum57[EXT_W:1] | {{(EXT_W-1){1'b0}}, sum57[0]};
            adj = 8'sd1;
        end else begin
            s_n = sum57[EXT_W-1:0];
            adj = 8'sd0;
        end

        // round to nearest even at 53 bits
        m_r = {1'b0, s_n[EXT_W-1:3]} +
              {{SIG_W{1'b0}}, s_n[2] && ((s_n[1:0] != 2'b00) || s_n[3])};
        if (m_r[SIG_W]) begin
            frac_res = m_r[FRAC_W:1];
            adj      = adj + 8'sd1;
        end else begin
            frac_res = m_r[FRAC_W-1:0];
        end

        e_res   = big_e + {{(XW-8){adj[7]}}, adj};
        rnd_sat = 1'b0;
        exp_res = e_res[EXP_WIDTH-1:0];
        if (e_res > EMAX) begin
            rnd_sat = 1'b1;
            exp_res = EMAX[EXP_WIDTH-1:0];
        end else if (e_res < EMIN) begin
            rnd_sat = 1'b1;
            exp_res = EMIN[EXP_WIDTH-1:0];
        end
    end

    // select the next sum
    logic                  n_acc_sign, n_acc_zero, n_sat;
    logic [FRAC_W-1:0]     n_acc_frac;
    logic [EXP_WIDTH-1:0]  n_acc_exp;

    always_comb begin
        n_acc_sign = r_acc_sign;
        n_acc_frac = r_acc_frac;
        n_acc_exp  = r_acc_exp;
        n_acc_zero = r_acc_zero;
        n_sat      = 1'b0;
        if (!r_add || r_acc_zero) begin
            if (r_oz) begin
                n_acc_sign = 1'b0;
                n_acc_frac = '0;
                n_acc_exp  = '0;
                n_acc_zero = 1'b1;
            end else begin
                n_acc_sign = r_os;
                n_acc_frac = r_of;
                n_acc_exp  = oe_c;
                n_acc_zero = 1'b0;
                n_sat      = oe_sat;
            end
        end else if (!r_oz) begin
            if (cancel) begin
                n_acc_sign = 1'b0;
                n_acc_frac = '0;
                n_acc_exp  = '0;
                n_acc_zero = 1'b1;
                n_sat      = oe_sat;
            end else begin
                n_acc_sign = big_s;
                n_acc_frac = frac_res;
                n_acc_exp  = exp_res;
                n_acc_zero = 1'b0;
                n_sat      = oe_sat || rnd_sat;
            end
        end
    end

    // update the sum and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_sign <= 1'b0;
            r_acc_frac <= '0;
            r_acc_exp  <= '0;
            r_acc_zero <= 1'b1;
            r_out_v    <= 1'b0;
            r_out_sat  <= 1'b0;
        end else begin
            if (adv) begin
                r_out_v <= r_in_v;
            end
            if (fire) begin
                r_acc_sign <= n_acc_sign;
                r_acc_frac <= n_acc_frac;
                r_acc_exp  <= n_acc_exp;
                r_acc_zero <= n_acc_zero;
                r_out_sat  <= n_sat;
            end
        end
    end

    // low 32 bits of the sign-extended exponent
    logic signed [XW-1:0] acc_exp_x;
    assign acc_exp_x = {{(XW-EXP_WIDTH){r_acc_exp[EXP_WIDTH-1]}}, r_acc_exp};

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_sat;
    assign m_axis_tdata  = {2'b00, r_acc_zero, acc_exp_x[OP_EXP_W-1:0], r_acc_frac,
                            r_acc_sign};

endmodule : extended_exponent_float_accumulator

`default_nettype wire
